FILE: hw/rtl/hpbb_pkg.sv
// Package for the hash partition block buffer.
// Constants, payload types and the front-to-back command struct; no dependencies.
package hpbb_pkg;
   localparam int MaxBuckets  = 16;
   localparam int MaxCapacity = 16;
   localparam int FieldBits   = 64;
   localparam int BktBits     = $clog2(MaxBuckets);
   localparam int PosBits     = $clog2(MaxCapacity);
   localparam int SlotBits    = BktBits + PosBits;
   localparam int StoreDepth  = MaxBuckets * MaxCapacity;
   localparam int QDepth      = 2;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_FLUSH  = 1'b1
   } op_type;

   typedef enum logic {
      CSR_BUCKET_COUNT   = 1'b0,
      CSR_BLOCK_CAPACITY = 1'b1
   } csr_idx_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_EMIT
   } bk_state_type;

   // Drain command from front to back.
   typedef struct packed {
      logic [5:0] bucket;
      logic [6:0] count;   // zero gives the empty marker
   } cmd_type;

   typedef struct packed {
      logic [5:0]  bucket;
      logic [63:0] tuple_id;
      logic [6:0]  block_count;
      logic        element_valid;
      logic [63:0] field_a;
      logic [63:0] field_b;
      logic        last;
   } rsp_type;

   function automatic logic [6:0] clamp7(input logic [6:0] v, input logic [6:0] hi);
      logic [6:0] r;
      r = v;
      if (v == 7'd0) r = 7'd1;
      else if (v > hi) r = hi;
      return r;
   endfunction
endpackage

FILE: hw/rtl/hpbb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module hpbb_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: hw/rtl/hpbb_modunit.sv
// Iterative restoring remainder unit for hash modulo bucket count.
// Depends on hpbb_pkg.
module hpbb_modunit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [6:0]  divisor,
   output logic        done,
   output logic [6:0]  remainder
);
   import hpbb_pkg::*;
   logic [31:0] q_ff, q_in;
   logic [7:0]  r_ff, r_in;
   logic [5:0]  n_ff, n_in;
   logic        busy_ff, busy_in;
   logic [7:0]  sh;

   always_comb begin
      q_in = q_ff; r_in = r_ff; n_in = n_ff; busy_in = busy_ff; done = 1'b0;
      sh = {r_ff[6:0], q_ff[31]};
      if (start) begin
         q_in = dividend; r_in = 8'd0; n_in = 6'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in = {q_ff[30:0], 1'b0};
         r_in = (sh >= {1'b0, divisor}) ? sh - {1'b0, divisor} : sh;
         n_in = n_ff + 6'd1;
         if (n_ff == 6'd31) begin
            busy_in = 1'b0;
            done = 1'b1;
         end
      end
   end
   assign remainder = r_in[6:0];

   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
      q_ff <= q_in; r_ff <= r_in; n_ff <= n_in;
   end
endmodule

FILE: hw/rtl/hpbb_front.sv
// Front end: accepts items, finds the bucket, writes the block store, updates
// fill counts and queues drain commands. Depends on hpbb_pkg, hpbb_modunit.
module hpbb_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  in_op,
   input  logic [31:0]           in_hash,
   input  logic [5:0]            in_fb,
   input  logic [6:0]            nb,
   input  logic [6:0]            cap,
   input  logic                  drain_idle,
   output logic                  wr_en,
   output logic [hpbb_pkg::SlotBits-1:0] wr_slot,
   output logic                  cmd_push,
   output hpbb_pkg::cmd_type     cmd,
   input  logic                  cmd_full
);
   import hpbb_pkg::*;
   logic [6:0] fill_ff [MaxBuckets];
   logic [6:0] fill_in [MaxBuckets];
   logic       busy_ff, busy_in;
   logic       pend_ff, pend_in;
   logic       mdone;
   logic [6:0] rem;
   logic [BktBits-1:0] bi;
   logic [6:0] pos;

   assign in_ready = !busy_ff && !cmd_full;

   hpbb_modunit u_mod (
      .clock(clock), .reset(reset),
      .start(in_valid && in_ready && in_op == OP_INSERT),
      .dividend(in_hash), .divisor(nb), .done(mdone), .remainder(rem)
   );

   // The remainder stays valid after done until the next start, so a store
   // write can wait there until every earlier drain has read its slots.
   always_comb begin
      fill_in = fill_ff;
      busy_in = busy_ff;
      pend_in = pend_ff;
      wr_en = 1'b0; cmd_push = 1'b0;
      cmd = '0;
      bi = rem[BktBits-1:0];
      pos = fill_ff[bi];
      if (pos >= 7'(MaxCapacity)) pos = 7'(MaxCapacity - 1);
      wr_slot = {bi, pos[PosBits-1:0]};
      if (in_valid && in_ready) begin
         if (in_op == OP_FLUSH) begin
            cmd_push = 1'b1;
            cmd.bucket = in_fb;
            if (in_fb < 6'(MaxBuckets)) begin
               cmd.count = fill_ff[in_fb[BktBits-1:0]];
               fill_in[in_fb[BktBits-1:0]] = 7'd0;
            end
         end else begin
            busy_in = 1'b1;
         end
      end else if ((mdone || pend_ff) && drain_idle) begin
         busy_in = 1'b0;
         pend_in = 1'b0;
         wr_en = 1'b1;
         if (pos + 7'd1 >= cap) begin
            cmd_push = 1'b1;
            cmd.bucket = 6'(bi);
            cmd.count = pos + 7'd1;
            fill_in[bi] = 7'd0;
         end else begin
            fill_in[bi] = pos + 7'd1;
         end
      end else if (mdone) begin
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
         for (int i = 0; i < MaxBuckets; i++) fill_ff[i] <= 7'd0;
      end else begin
         busy_ff <= busy_in;
         pend_ff <= pend_in;
         fill_ff <= fill_in;
      end
   end

`ifndef SYNTHESIS
   a_wr_push: assert property (@(posedge clock) disable iff (reset)
      cmd_push && !in_valid |-> wr_en) else $error("drain push without store write");
   a_busy_block: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !in_ready) else $error("accept while hashing");
   a_count_nz: assert property (@(posedge clock) disable iff (reset)
      wr_en && cmd_push |-> cmd.count != 7'd0) else $error("empty full-block drain");
`endif
endmodule

FILE: hw/rtl/hpbb_back.sv
// Back end: pops drain commands, reads the block store and emits beats.
// Depends on hpbb_pkg.
module hpbb_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  hpbb_pkg::cmd_type     cmd,
   output logic                  cmd_pop,
   output logic                  idle,
   output logic [hpbb_pkg::SlotBits-1:0] rd_slot,
   input  logic [63:0]           rd_a,
   input  logic [63:0]           rd_b,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hpbb_pkg::rsp_type     out
);
   import hpbb_pkg::*;
   bk_state_type st_ff, st_in;
   cmd_type      cur_ff, cur_in;
   logic [6:0]   idx_ff, idx_in;
   logic [63:0]  id_ff, id_in;
   logic [6:0]   cnt;

   assign idle = (st_ff == BK_IDLE);
   assign cnt = (cur_ff.count > 7'(MaxCapacity)) ? 7'(MaxCapacity) : cur_ff.count;
   assign rd_slot = {cur_ff.bucket[BktBits-1:0], idx_ff[PosBits-1:0]};

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         BK_IDLE: if (cmd_valid) st_in = BK_READ;
         BK_READ: st_in = BK_EMIT;
         BK_EMIT: if (out_ready) st_in = (cnt == 7'd0 || idx_ff + 7'd1 == cnt) ?
                                          BK_IDLE : BK_READ;
         default: st_in = BK_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop = 1'b0; cur_in = cur_ff; idx_in = idx_ff; id_in = id_ff;
      out_valid = (st_ff == BK_EMIT);
      out.bucket = cur_ff.bucket;
      out.tuple_id = id_ff + 64'(idx_ff);
      out.block_count = cnt;
      out.element_valid = (cnt != 7'd0);
      out.field_a = (cnt != 7'd0) ? rd_a : 64'd0;
      out.field_b = (cnt != 7'd0) ? rd_b : 64'd0;
      out.last = (cnt == 7'd0) || (idx_ff + 7'd1 == cnt);
      unique case (st_ff)
         BK_IDLE: if (cmd_valid) begin
            cmd_pop = 1'b1; cur_in = cmd; idx_in = 7'd0;
         end
         BK_EMIT: if (out_ready) begin
            if (out.last) id_in = id_ff + 64'(cnt);
            else idx_in = idx_ff + 7'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BK_IDLE; id_ff <= 64'd0;
      end else begin
         st_ff <= st_in; id_ff <= id_in;
      end
      cur_ff <= cur_in; idx_ff <= idx_in;
   end

`ifndef SYNTHESIS
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> st_ff == BK_IDLE) else $error("pop while busy");
   a_emit_after_read: assert property (@(posedge clock) disable iff (reset)
      st_ff == BK_EMIT && !$past(st_ff == BK_EMIT) |-> $past(st_ff == BK_READ))
      else $error("emit without store read");
   a_id_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> $stable(id_ff)) else $error("id moved on stall");
`endif
endmodule

FILE: hw/rtl/hash_partition_block_buffer_top.sv
// Hash partition block buffer: an insert holds the input through accept and then 32
// remainder steps, longer while an earlier drain is still queued or emitting.
// A flush is taken while no insert is in progress and the drain queue has room.
// A drain, whether from a flush or from a full block, reaches its first beat through
// the drain queue and a back-end pop; each beat is a store read, then an emit.
// Reset is synchronous active high: fill counts, tuple id, queue and state clear,
// registers return to 16; the block store is not cleared and needs no pass.
module hash_partition_block_buffer_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tuser: operation[0].
   input  logic         req_tuser,
   // tdata: key_hash[31:0], flush_bucket[37:32], field_a[101:38],
   // field_b[165:102], zero fill to 168 bits.
   input  logic [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tuser: element_valid[0].
   output logic         rsp_tuser,
   // tdata: bucket[5:0], tuple_id[69:6], block_count[76:70],
   // out_field_a[140:77], out_field_b[204:141], zero fill to 208 bits.
   output logic [207:0] rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [6:0]   csr_data
);
   import hpbb_pkg::*;

   logic [6:0] nbreg_ff, capreg_ff;
   logic [6:0] nb, cap;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         nbreg_ff <= 7'd16; capreg_ff <= 7'd16;
      end else if (csr_valid) begin
         if (csr_index == CSR_BUCKET_COUNT) nbreg_ff <= csr_data;
         else capreg_ff <= csr_data;
      end
   end
   assign nb  = clamp7(nbreg_ff, 7'(MaxBuckets));
   assign cap = clamp7(capreg_ff, 7'(MaxCapacity));

   // Drain command queue between the two halves.
   cmd_type q_ff [QDepth];
   logic [$clog2(QDepth):0] qc_ff;
   logic [$clog2(QDepth)-1:0] qh_ff, qt_ff;
   logic push, pop;
   cmd_type pcmd;
   logic bk_idle;

   logic wr_en;
   logic [SlotBits-1:0] wr_slot, rd_slot;
   logic [63:0] rd_a, rd_b;
   rsp_type rsp;

   // A store write waits until no drain is queued or emitting, so a block is
   // never overwritten before the back end has read it.
   hpbb_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .in_op(req_tuser), .in_hash(req_tdata[31:0]), .in_fb(req_tdata[37:32]),
      .nb(nb), .cap(cap), .drain_idle(qc_ff == '0 && bk_idle),
      .wr_en(wr_en), .wr_slot(wr_slot),
      .cmd_push(push), .cmd(pcmd), .cmd_full(qc_ff == ($clog2(QDepth)+1)'(QDepth))
   );

   // Fields ride along until the hash remainder is known.
   logic [63:0] fa_ff, fb_ff;
   always_ff @(posedge clock)
      if (req_tvalid && req_tready) begin
         fa_ff <= req_tdata[101:38]; fb_ff <= req_tdata[165:102];
      end

   hpbb_ram #(.Width(FieldBits), .Depth(StoreDepth)) u_ram_a (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_slot), .wr_data(fa_ff),
      .rd_addr(rd_slot), .rd_data(rd_a));
   hpbb_ram #(.Width(FieldBits), .Depth(StoreDepth)) u_ram_b (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_slot), .wr_data(fb_ff),
      .rd_addr(rd_slot), .rd_data(rd_b));

   always_ff @(posedge clock) begin
      if (reset) begin
         qc_ff <= '0; qh_ff <= '0; qt_ff <= '0;
      end else begin
         if (push) begin q_ff[qt_ff] <= pcmd; qt_ff <= qt_ff + 1'b1; end
         if (pop) qh_ff <= qh_ff + 1'b1;
         qc_ff <= qc_ff + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
      end
   end

   hpbb_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(qc_ff != '0), .cmd(q_ff[qh_ff]),
      .cmd_pop(pop), .idle(bk_idle), .rd_slot(rd_slot), .rd_a(rd_a), .rd_b(rd_b),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out(rsp)
   );

   assign rsp_tdata = {3'b000, rsp.field_b, rsp.field_a,
                       rsp.block_count, rsp.tuple_id, rsp.bucket};
   assign rsp_tuser = rsp.element_valid;
   assign rsp_tlast = rsp.last;

`ifndef SYNTHESIS
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      qc_ff <= ($clog2(QDepth)+1)'(QDepth)) else $error("queue overflow");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> qc_ff != '0) else $error("pop of empty queue");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> qc_ff < ($clog2(QDepth)+1)'(QDepth)) else $error("push into full queue");
`endif
endmodule

FILE: test/tb_hash_partition_block_buffer_top.sv
// Self-checking testbench for the hash partition block buffer top level.
// Depends on hpbb_pkg and hash_partition_block_buffer_top only.
module tb_hash_partition_block_buffer_top;
   timeunit 1ns;
   timeprecision 1ps;
   import hpbb_pkg::*;

   localparam int IdleLimit = 2000000;

   // One tuple or flush request as the front end sees it.
   typedef struct {
      op_type      op;
      logic [31:0] key_hash;
      logic [5:0]  flush_bucket;
      logic [63:0] field_a;
      logic [63:0] field_b;
   } tuple_req_type;

   // A row of the directed table; has_exp marks a result typed in by hand.
   typedef struct {
      tuple_req_type req;
      bit            has_exp;
      rsp_type       exp;
   } table_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic         req_tuser;
   logic [167:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic         rsp_tuser;
   logic [207:0] rsp_tdata;
   logic         rsp_tlast;
   logic         csr_valid;
   logic         csr_ready;
   logic         csr_index;
   logic [6:0]   csr_data;

   hash_partition_block_buffer_top u_top (.*);

   // Predictor state: a private copy of the partitioner.
   logic [6:0]  bkt_count_reg;
   logic [6:0]  capacity_reg;
   logic [6:0]  fill [MaxBuckets];
   logic [63:0] store_a [StoreDepth];
   logic [63:0] store_b [StoreDepth];
   logic [63:0] next_id;

   rsp_type     expected_beats[$];
   int          errors;
   longint      cycle_count;
   bit          idle_enable;
   bit          rsp_free_run;

   initial begin
      clock = 1'b0;
   end
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > IdleLimit) begin
         $display("%0t: timeout with %0d beats outstanding", $realtime, expected_beats.size());
         $display("tb: failure");
         $finish;
      end
   end

   // Drain one bucket into the expected-beat queue.
   function automatic void drain_block(input logic [5:0] b);
      logic [6:0] n;
      rsp_type    r;
      n = fill[b];
      if (n > MaxCapacity) n = 7'(MaxCapacity);
      if (n == 0) begin
         r = '{bucket: b, tuple_id: next_id, block_count: 7'd0, element_valid: 1'b0,
               field_a: '0, field_b: '0, last: 1'b1};
         expected_beats.insert(expected_beats.size(), r);
         return;
      end
      for (int i = 0; i < n; i++) begin
         r = '{bucket: b, tuple_id: next_id + 64'(i), block_count: n, element_valid: 1'b1,
               field_a: store_a[b*MaxCapacity+i], field_b: store_b[b*MaxCapacity+i],
               last: (i == n - 1)};
         expected_beats.insert(expected_beats.size(), r);
      end
      next_id += 64'(n);
      fill[b] = '0;
   endfunction

   function automatic void partition_tuple(input tuple_req_type t);
      logic [6:0] nb, cap, pos;
      logic [5:0] b;
      rsp_type    r;
      if (t.op == OP_FLUSH) begin
         if (t.flush_bucket >= MaxBuckets) begin
            r = '{bucket: t.flush_bucket, tuple_id: next_id,
               block_count: 7'd0, element_valid: 1'b0, field_a: '0, field_b: '0,
               last: 1'b1};
            expected_beats.insert(expected_beats.size(), r);
         end else begin
            drain_block(t.flush_bucket);
         end
         return;
      end
      nb  = (bkt_count_reg == 0) ? 7'd1 : (bkt_count_reg > MaxBuckets) ? 7'(MaxBuckets)
                                                                         : bkt_count_reg;
      cap = (capacity_reg == 0) ? 7'd1 : (capacity_reg > MaxCapacity) ? 7'(MaxCapacity)
                                                                       : capacity_reg;
      b   = 6'(t.key_hash % 32'(nb));
      pos = fill[b];
      if (pos >= MaxCapacity) pos = 7'(MaxCapacity - 1);
      store_a[b*MaxCapacity+pos] = t.field_a;
      store_b[b*MaxCapacity+pos] = t.field_b;
      fill[b] = pos + 7'd1;
      if (pos + 7'd1 >= cap) drain_block(b);
   endfunction

   // Result side: random back-pressure, compare each beat with the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_type got, want;
            got = '{bucket: rsp_tdata[5:0], tuple_id: rsp_tdata[69:6],
                    block_count: rsp_tdata[76:70], element_valid: rsp_tuser,
                    field_a: rsp_tdata[140:77], field_b: rsp_tdata[204:141],
                    last: rsp_tlast};
            if (expected_beats.size() == 0) begin
               $display("%0t: unexpected beat %p", $realtime, got);
               errors++;
            end else begin
               want = expected_beats.pop_front();
               if (got.bucket !== want.bucket)
                  $display("%0t: bucket exp %0d got %0d", $realtime, want.bucket, got.bucket);
               if (got.tuple_id !== want.tuple_id)
                  $display("%0t: tuple_id exp %0d got %0d", $realtime, want.tuple_id,
                           got.tuple_id);
               if (got.block_count !== want.block_count)
                  $display("%0t: block_count exp %0d got %0d", $realtime, want.block_count,
                           got.block_count);
               if (got.element_valid !== want.element_valid)
                  $display("%0t: element_valid exp %0b got %0b", $realtime,
                           want.element_valid, got.element_valid);
               if (got.field_a !== want.field_a)
                  $display("%0t: field_a exp %h got %h", $realtime, want.field_a, got.field_a);
               if (got.field_b !== want.field_b)
                  $display("%0t: field_b exp %h got %h", $realtime, want.field_b, got.field_b);
               if (got.last !== want.last)
                  $display("%0t: last exp %0b got %0b", $realtime, want.last, got.last);
               if (got !== want) errors++;
            end
         end
         rsp_tready <= rsp_free_run || !idle_enable || ($urandom_range(99) >= 16);
      end
   end

   // Send one request beat; the predictor runs at acceptance. Valid stays high
   // afterwards so that back-to-back beats need one assignment per edge.
   task automatic send_tuple(input tuple_req_type t);
      while (idle_enable && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= t.op;
      req_tdata  <= {2'b00, t.field_b, t.field_a, t.flush_bucket, t.key_hash};
      do @(posedge clock); while (!req_tready);
      partition_tuple(t);
   endtask

   // Register write, only while idle.
   task automatic write_csr(input csr_idx_type idx, input logic [6:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_BUCKET_COUNT) bkt_count_reg = value;
      else capacity_reg = value;
      @(posedge clock);
   endtask

   // Wait for every expected beat, then a quiet spell covering an insert's latency.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic tuple_req_type random_tuple(input int flush_pct);
      tuple_req_type t;
      t.op           = ($urandom_range(99) < flush_pct) ? OP_FLUSH : OP_INSERT;
      t.key_hash     = $urandom();
      t.flush_bucket = ($urandom_range(9) == 0) ? 6'($urandom_range(63, 16))
                                                : 6'($urandom_range(15));
      t.field_a      = {$urandom(), $urandom()};
      t.field_b      = {$urandom(), $urandom()};
      return t;
   endfunction

   table_row_type dir_table[$];

   initial begin
      tuple_req_type t;
      table_row_type row;
      errors       = 0;
      cycle_count  = 0;
      idle_enable  = 1'b1;
      rsp_free_run = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tuser    = 1'b0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_BUCKET_COUNT;
      csr_data     = '0;
      bkt_count_reg = 7'd16;
      capacity_reg  = 7'd16;
      next_id       = '0;
      foreach (fill[i]) fill[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table. Flush of an empty bucket after reset, and of a bucket
      // with no storage, give the empty marker with id zero.
      row = '{req: '{OP_FLUSH, '0, 6'd0, '0, '0}, has_exp: 1'b1,
              exp: '{6'd0, 64'd0, 7'd0, 1'b0, 64'd0, 64'd0, 1'b1}};
      dir_table.insert(dir_table.size(), row);
      row = '{req: '{OP_FLUSH, '1, 6'd63, '1, '1}, has_exp: 1'b1,
              exp: '{6'd63, 64'd0, 7'd0, 1'b0, 64'd0, 64'd0, 1'b1}};
      dir_table.insert(dir_table.size(), row);
      row.has_exp = 1'b0;
      row.req = '{OP_INSERT, 32'hFFFF_FFFF, 6'd0, '1, '1};
      dir_table.insert(dir_table.size(), row);
      row.req = '{OP_INSERT, 32'h0000_0000, 6'd63, '0, '0};
      dir_table.insert(dir_table.size(), row);
      row.req = '{OP_INSERT, 32'h0000_000F, 6'd0, 64'hA5A5, 64'h5A5A};
      dir_table.insert(dir_table.size(), row);
      row.req = '{OP_FLUSH, '0, 6'd15, '0, '0};
      dir_table.insert(dir_table.size(), row);
      row.req = '{OP_FLUSH, '0, 6'd0, '0, '0};
      dir_table.insert(dir_table.size(), row);
      row.req = '{OP_FLUSH, '0, 6'd16, '0, '0};
      dir_table.insert(dir_table.size(), row);
      for (int i = 0; i < 17; i++) begin
         row.req = '{OP_INSERT, 32'(16 * i + 3), 6'd0, 64'(i), ~64'(i)};
         dir_table.insert(dir_table.size(), row);
      end

      foreach (dir_table[i]) begin
         if (dir_table[i].has_exp) begin
            int depth;
            depth = expected_beats.size();
            send_tuple(dir_table[i].req);
            if (expected_beats[depth] !== dir_table[i].exp) begin
               $display("%0t: table row %0d exp %p model %p", $realtime, i,
                        dir_table[i].exp, expected_beats[depth]);
               errors++;
            end
         end else begin
            send_tuple(dir_table[i].req);
         end
      end
      wait_drained();

      // Extremes: capacity 1 drains every insert; zero values act as one.
      write_csr(CSR_BLOCK_CAPACITY, 7'd0);
      write_csr(CSR_BUCKET_COUNT, 7'd0);
      for (int i = 0; i < 6; i++) send_tuple(random_tuple(10));
      wait_drained();

      // Fill a few buckets, then lower the capacity below the fill.
      write_csr(CSR_BUCKET_COUNT, 7'd4);
      write_csr(CSR_BLOCK_CAPACITY, 7'd64);
      for (int i = 0; i < 12; i++) send_tuple(random_tuple(0));
      wait_drained();
      write_csr(CSR_BLOCK_CAPACITY, 7'd2);
      for (int i = 0; i < 4; i++) send_tuple(random_tuple(0));
      wait_drained();

      // Random phases over several register settings; flushes also name
      // buckets beyond the count in use.
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(CSR_BUCKET_COUNT, (ph == 0) ? 7'd127 : 7'($urandom_range(127)));
         write_csr(CSR_BLOCK_CAPACITY, (ph == 1) ? 7'd1 : 7'($urandom_range(1, 20)));
         idle_enable = (ph != 3);
         for (int i = 0; i < 36; i++) begin
            send_tuple(random_tuple(15));
            // Hold the sender until the result side has caught up.
            if (i == 18) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
               while (expected_beats.size() != 0) @(posedge clock);
            end
         end
         wait_drained();
      end
      idle_enable = 1'b1;
      write_csr(CSR_BUCKET_COUNT, 7'd16);
      write_csr(CSR_BLOCK_CAPACITY, 7'd16);
      for (int i = 0; i < 16; i++) begin
         t = random_tuple(0);
         t.op = OP_FLUSH;
         t.flush_bucket = 6'(i);
         send_tuple(t);
      end
      wait_drained();

      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
